// ===== sv/sqs_pkg.sv =====
// Shared types, constants and keyword match for the SQL statement splitter.
package sqs_pkg;

	localparam int HoldMax      = 6;
	localparam int QueueDepthDf = 4;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
	} sqs_in_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] out_byte;
		logic       last;
	} sqs_out_t;

	localparam logic CMD_BYTE   = 1'b0;
	localparam logic CMD_FINISH = 1'b1;
	localparam logic KIND_BYTE  = 1'b0;
	localparam logic KIND_END   = 1'b1;

	// Results of one transaction, in emit order:
	// pre_end, held[0..held_n-1], byte_c, post_end.
	typedef struct packed {
		logic                          pre_end;
		logic [2:0]                    held_n;
		logic [HoldMax-1:0][7:0]       held;
		logic                          has_c;
		logic [7:0]                    byte_c;
		logic                          post_end;
	} sqs_desc_t;

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		to_upper = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
	endfunction

	function automatic logic held_is_kw(input logic [HoldMax-1:0][7:0] h,
		input logic [2:0] n);
		logic [47:0] w6;
		logic [39:0] w5;
		logic [31:0] w4;
		w6 = {to_upper(h[0]), to_upper(h[1]), to_upper(h[2]),
			to_upper(h[3]), to_upper(h[4]), to_upper(h[5])};
		w5 = w6[47:8];
		w4 = w6[47:16];
		case (n)
			3'd4: held_is_kw = (w4 == "DROP");
			3'd5: held_is_kw = (w5 == "ALTER");
			3'd6: held_is_kw = (w6 == "CREATE") || (w6 == "DELETE") ||
				(w6 == "INSERT") || (w6 == "SELECT") || (w6 == "UPDATE");
			default: held_is_kw = 1'b0;
		endcase
	endfunction

endpackage

// ===== sv/sql_statement_splitter_top.sv =====
// Top level of the SQL statement splitter.
// Each accepted transaction (one text byte or a finish command) is classified
// combinationally by the front end and turned into a descriptor of 0 to 9
// results; the back end sends those results one per cycle, while result_stall
// is low, through a registered output. An item that causes k results therefore
// holds the back end until all k are sent; a queue of QueueDepth descriptors
// absorbs bursts from flushed identifiers, and the input stalls only while that queue is full.
module sql_statement_splitter_top #(
	parameter int QueueDepth = sqs_pkg::QueueDepthDf
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  sqs_pkg::sqs_in_t  item,
	output logic              result_valid,
	input  logic              result_stall,
	output sqs_pkg::sqs_out_t result
);

	sqs_pkg::sqs_desc_t desc, q_data;
	logic full, push, pop, q_valid, take;

	assign item_stall = full;
	assign take = item_valid && !full;

	sqs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item),
		.push   (push),
		.desc   (desc)
	);

	sqs_queue #(.Depth(QueueDepth)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  (desc),
		.pop      (pop),
		.full     (full),
		.rd_valid (q_valid),
		.rd_data  (q_data)
	);

	sqs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (q_data),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== sv/sqs_front.sv =====
// Front end: tokenizer state and per-transaction result descriptor.
module sqs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  sqs_pkg::sqs_in_t  item,
	output logic              push,
	output sqs_pkg::sqs_desc_t desc
);

	typedef enum logic [5:0] {
		MODE_BETWEEN = 6'b000001,
		MODE_SPACE   = 6'b000010,
		MODE_DIGITS  = 6'b000100,
		MODE_QUOTE   = 6'b001000,
		MODE_BRACKET = 6'b010000,
		MODE_IDENT   = 6'b100000
	} sqs_mode_t;

	sqs_mode_t mode_q, mode_d;
	logic quote_bt_q, quote_bt_d;
	logic [sqs_pkg::HoldMax-1:0][7:0] held_q, held_d;
	logic [2:0] held_cnt_q, held_cnt_d;
	logic maybe_kw_q, maybe_kw_d;
	logic armed_q, armed_d;
	logic open_q, open_d;
	logic [3:0] total;

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = (c >= 8'h30 && c <= 8'h39);
	endfunction

	function automatic logic is_id(input logic [7:0] c);
		is_id = c[7] || c == 8'h05 || c == 8'h2D || c == 8'h5F || is_digit(c) ||
			(c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_space_start(input logic [7:0] c);
		is_space_start = c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0C;
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		is_punct = c == 8'h2D || c == 8'h28 || c == 8'h29 || c == 8'h2A ||
			c == 8'h3D || c == 8'h3C || c == 8'h3E || c == 8'h21 ||
			c == 8'h3F || c == 8'h2C || c == 8'h2E;
	endfunction

	always_comb begin
		logic [7:0] c;
		logic start;
		c = item.data_byte;
		start = 1'b0;
		mode_d = mode_q;
		quote_bt_d = quote_bt_q;
		held_d = held_q;
		held_cnt_d = held_cnt_q;
		maybe_kw_d = maybe_kw_q;
		armed_d = armed_q;
		open_d = open_q;
		desc = '0;
		desc.held = held_q;
		desc.byte_c = c;

		if (item.cmd == sqs_pkg::CMD_FINISH) begin
			if (mode_q == MODE_IDENT) begin
				if (maybe_kw_q && armed_q && sqs_pkg::held_is_kw(held_q, held_cnt_q)) begin
					desc.pre_end = open_d;
					open_d = 1'b0;
				end
				desc.held_n = held_cnt_q;
				if (held_cnt_q != 3'd0)
					open_d = 1'b1;
			end
			desc.post_end = open_d;
			open_d = 1'b0;
			armed_d = 1'b0;
			mode_d = MODE_BETWEEN;
			held_cnt_d = 3'd0;
			maybe_kw_d = 1'b1;
		end else begin
			case (mode_q)
				MODE_SPACE: begin
					if (c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B ||
						c == 8'h0C) begin
						desc.has_c = 1'b1;
						open_d = 1'b1;
					end else
						start = 1'b1;
				end
				MODE_DIGITS: begin
					if (is_digit(c)) begin
						desc.has_c = 1'b1;
						open_d = 1'b1;
					end else
						start = 1'b1;
				end
				MODE_QUOTE: begin
					desc.has_c = 1'b1;
					open_d = 1'b1;
					if (c == (quote_bt_q ? 8'h60 : 8'h27))
						mode_d = MODE_BETWEEN;
				end
				MODE_BRACKET: begin
					desc.has_c = 1'b1;
					open_d = 1'b1;
					if (c == 8'h5D)
						mode_d = MODE_BETWEEN;
				end
				MODE_IDENT: begin
					if (!is_id(c)) begin
						if (maybe_kw_q && armed_q &&
							sqs_pkg::held_is_kw(held_q, held_cnt_q)) begin
							desc.pre_end = open_d;
							open_d = 1'b0;
						end
						desc.held_n = held_cnt_q;
						if (held_cnt_q != 3'd0)
							open_d = 1'b1;
						held_cnt_d = 3'd0;
						maybe_kw_d = 1'b1;
						armed_d = 1'b1;
						start = 1'b1;
					end else if (!maybe_kw_q) begin
						desc.has_c = 1'b1;
						open_d = 1'b1;
					end else if (held_cnt_q < 3'(sqs_pkg::HoldMax)) begin
						held_d[held_cnt_q] = c;
						held_cnt_d = held_cnt_q + 3'd1;
					end else begin
						desc.held_n = held_cnt_q;
						desc.has_c = 1'b1;
						open_d = 1'b1;
						held_cnt_d = 3'd0;
						maybe_kw_d = 1'b0;
					end
				end
				default: start = 1'b1;
			endcase

			if (start) begin
				mode_d = MODE_BETWEEN;
				if (c == 8'h3B) begin
					desc.post_end = open_d;
					open_d = 1'b0;
					armed_d = 1'b0;
				end else if (is_space_start(c)) begin
					desc.has_c = 1'b1;
					open_d = 1'b1;
					armed_d = 1'b1;
					mode_d = MODE_SPACE;
				end else if (is_punct(c)) begin
					desc.has_c = 1'b1;
					open_d = 1'b1;
					armed_d = 1'b1;
				end else if (c == 8'h60 || c == 8'h27) begin
					desc.has_c = 1'b1;
					open_d = 1'b1;
					armed_d = 1'b1;
					quote_bt_d = (c == 8'h60);
					mode_d = MODE_QUOTE;
				end else if (is_digit(c)) begin
					desc.has_c = 1'b1;
					open_d = 1'b1;
					armed_d = 1'b1;
					mode_d = MODE_DIGITS;
				end else if (c == 8'h5B) begin
					desc.has_c = 1'b1;
					open_d = 1'b1;
					armed_d = 1'b1;
					mode_d = MODE_BRACKET;
				end else if (is_id(c)) begin
					held_d[0] = c;
					held_cnt_d = 3'd1;
					maybe_kw_d = 1'b1;
					mode_d = MODE_IDENT;
				end else begin
					desc.has_c = 1'b1;
					desc.post_end = 1'b1;
					open_d = 1'b0;
					armed_d = 1'b0;
				end
			end
		end
	end

	assign total = {3'd0, desc.pre_end} + {1'b0, desc.held_n} + {3'd0, desc.has_c} +
		{3'd0, desc.post_end};
	assign push = take && (total != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BETWEEN;
			quote_bt_q <= 1'b0;
			held_cnt_q <= 3'd0;
			maybe_kw_q <= 1'b1;
			armed_q <= 1'b0;
			open_q <= 1'b0;
		end else if (take) begin
			mode_q <= mode_d;
			quote_bt_q <= quote_bt_d;
			held_cnt_q <= held_cnt_d;
			maybe_kw_q <= maybe_kw_d;
			armed_q <= armed_d;
			open_q <= open_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			held_q <= held_d;
	end

endmodule

// ===== sv/sqs_queue.sv =====
// Descriptor queue between front and back.
module sqs_queue #(
	parameter int Depth = sqs_pkg::QueueDepthDf
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sqs_pkg::sqs_desc_t wr_data,
	input  logic               pop,
	output logic               full,
	output logic               rd_valid,
	output sqs_pkg::sqs_desc_t rd_data
);

	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	sqs_pkg::sqs_desc_t mem_q [Depth];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(Depth));
	assign rd_valid = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== sv/sqs_back.sv =====
// Back end: expands descriptors into result transactions, one per cycle while result_stall is low.
module sqs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  sqs_pkg::sqs_desc_t q_data,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output sqs_pkg::sqs_out_t  result
);

	sqs_pkg::sqs_desc_t cur_q;
	logic cur_valid_q;
	logic [3:0] idx_q;
	logic out_valid_q;
	sqs_pkg::sqs_out_t out_q, nxt;
	logic [3:0] total, j;
	logic load, is_last;

	assign total = {3'd0, cur_q.pre_end} + {1'b0, cur_q.held_n} +
		{3'd0, cur_q.has_c} + {3'd0, cur_q.post_end};
	assign j = idx_q - {3'd0, cur_q.pre_end};
	assign is_last = (idx_q == total - 4'd1);
	assign load = cur_valid_q && (!out_valid_q || !result_stall);
	assign pop = q_valid && (!cur_valid_q || (load && is_last));

	always_comb begin
		nxt.kind = sqs_pkg::KIND_END;
		nxt.out_byte = 8'd0;
		nxt.last = is_last;
		if (!(cur_q.pre_end && idx_q == 4'd0)) begin
			if (j < {1'b0, cur_q.held_n}) begin
				nxt.kind = sqs_pkg::KIND_BYTE;
				nxt.out_byte = cur_q.held[j[2:0]];
			end else if (j == {1'b0, cur_q.held_n} && cur_q.has_c) begin
				nxt.kind = sqs_pkg::KIND_BYTE;
				nxt.out_byte = cur_q.byte_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q <= 4'd0;
			end else if (load) begin
				if (is_last)
					cur_valid_q <= 1'b0;
				else
					idx_q <= idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= q_data;
		if (load)
			out_q <= nxt;
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == sqs_pkg::KIND_END |-> out_q.out_byte == 8'd0)
		else $error("end mark carries a byte");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> idx_q < total)
		else $error("result index past descriptor");
	a_no_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> total != 4'd0)
		else $error("empty descriptor in back end");
	a_load_moves: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q)
		else $error("loaded result lost");

endmodule

// ===== dv/tb_sql_statement_splitter_top.sv =====
// Self-checking testbench for the SQL statement splitter: directed table, random SQL text.
module tb_sql_statement_splitter_top;

	localparam int CycleLimit  = 400000;
	localparam int RandItems   = 470;
	localparam int TailItems   = 60;
	localparam int HoldCycles  = 120;
	localparam int HoldAt      = 150;
	localparam int DrainAt     = 320;
	localparam int DirRows     = 25;
	localparam logic [7:0] ChBacktick = 8'h60;
	localparam logic [7:0] ChApos     = 8'h27;

	typedef enum logic [2:0] {
		TM_GAP, TM_SPACE, TM_DIGITS, TM_QUOTE, TM_BRACKET, TM_IDENT
	} tok_mode_t;

	typedef struct {
		logic              cmd;
		logic [7:0]        b;
		bit                chk;
		int                n;
		sqs_pkg::sqs_out_t first;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	sqs_pkg::sqs_in_t  item;
	logic              result_valid;
	logic              result_stall;
	sqs_pkg::sqs_out_t result;

	int cycle_cnt  = 0;
	int mismatches = 0;
	bit hold_req   = 1'b0;
	bit tail_quiet = 1'b0;

	// splitter state as seen by the predictor
	tok_mode_t  tm          = TM_GAP;
	logic       quote_bt    = 1'b0;
	logic [7:0] pend [sqs_pkg::HoldMax];
	int         pend_n      = 0;
	logic       kw_possible = 1'b1;
	logic       kw_live     = 1'b0;
	logic       stmt_open   = 1'b0;

	sqs_pkg::sqs_out_t step_res [$];
	sqs_pkg::sqs_out_t split_out_q [$];
	sqs_pkg::sqs_in_t  rand_q [$];

	string      kw_list [7]    = '{"ALTER", "CREATE", "DELETE", "DROP", "INSERT", "SELECT",
		"UPDATE"};
	logic [7:0] ws_set [5]     = '{8'h20, 8'h09, 8'h0A, 8'h0C, 8'h0B};
	logic [7:0] punct_set [11] = '{"-", "(", ")", "*", "=", "<", ">", "!", "?", ",", "."};
	logic [7:0] unk_set [8]    = '{8'h00, 8'h0D, 8'h7F, 8'h40, 8'h23, 8'h22, 8'h7B, 8'h01};

	dir_row_t dir_tab [DirRows] = '{
		'{sqs_pkg::CMD_FINISH, 8'h00, 1'b1, 0, '0},
		'{sqs_pkg::CMD_BYTE, 8'h00, 1'b1, 2, {sqs_pkg::KIND_BYTE, 8'h00, 1'b0}},
		'{sqs_pkg::CMD_BYTE, "s", 1'b0, 0, '0},
		'{sqs_pkg::CMD_BYTE, "E", 1'b0, 0, '0},
		'{sqs_pkg::CMD_BYTE, "l", 1'b0, 0, '0},
		'{sqs_pkg::CMD_BYTE, "e", 1'b0, 0, '0},
		'{sqs_pkg::CMD_BYTE, "c", 1'b0, 0, '0},
		'{sqs_pkg::CMD_BYTE, "t", 1'b0, 0, '0},
		'{sqs_pkg::CMD_BYTE, 8'h0B, 1'b0, 0, '0},
		'{sqs_pkg::CMD_BYTE, 8'h20, 1'b0, 0, '0},
		'{sqs_pkg::CMD_BYTE, "i", 1'b0, 0, '0},
		'{sqs_pkg::CMD_BYTE, "N", 1'b0, 0, '0},
		'{sqs_pkg::CMD_BYTE, "s", 1'b0, 0, '0},
		'{sqs_pkg::CMD_BYTE, "E", 1'b0, 0, '0},
		'{sqs_pkg::CMD_BYTE, "r", 1'b0, 0, '0},
		'{sqs_pkg::CMD_BYTE, "T", 1'b0, 0, '0},
		'{sqs_pkg::CMD_BYTE, 8'h7F, 1'b1, 9, {sqs_pkg::KIND_END, 8'h00, 1'b0}},
		'{sqs_pkg::CMD_BYTE, 8'h80, 1'b0, 0, '0},
		'{sqs_pkg::CMD_BYTE, 8'h05, 1'b0, 0, '0},
		'{sqs_pkg::CMD_BYTE, "-", 1'b0, 0, '0},
		'{sqs_pkg::CMD_BYTE, "_", 1'b0, 0, '0},
		'{sqs_pkg::CMD_BYTE, "9", 1'b0, 0, '0},
		'{sqs_pkg::CMD_BYTE, "z", 1'b0, 0, '0},
		'{sqs_pkg::CMD_BYTE, "Z", 1'b1, 7, {sqs_pkg::KIND_BYTE, 8'h80, 1'b0}},
		'{sqs_pkg::CMD_FINISH, 8'hFF, 1'b1, 1, {sqs_pkg::KIND_END, 8'h00, 1'b1}}
	};

	sql_statement_splitter_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CycleLimit) begin
			$display("sql_statement_splitter_top regression: fail");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_cnt, what, got, want);
		mismatches++;
	endtask

	// ---------------- predictor ----------------

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_ident(input logic [7:0] c);
		return c >= 8'h80 || c == 8'h05 || c == "-" || c == "_" || is_digit(c) ||
			(c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic bit is_ws_cont(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C;
	endfunction

	function automatic bit is_punct(input logic [7:0] c);
		case (c)
			"-", "(", ")", "*", "=", "<", ">", "!", "?", ",", ".": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic void put_res(input logic k, input logic [7:0] b);
		step_res.push_back({k, k ? 8'h00 : b, 1'b0});
	endfunction

	function automatic void emit_text(input logic [7:0] c);
		put_res(sqs_pkg::KIND_BYTE, c);
		stmt_open = 1'b1;
	endfunction

	function automatic void close_stmt();
		if (stmt_open)
			put_res(sqs_pkg::KIND_END, 8'h00);
		stmt_open = 1'b0;
		kw_live   = 1'b0;
	endfunction

	function automatic bit pend_is_keyword();
		string      w;
		logic [7:0] c;
		w = "";
		for (int i = 0; i < pend_n; i++) begin
			c = pend[i];
			if (c > 8'd127)
				return 1'b0;
			if (c >= "a" && c <= "z")
				c = c - 8'd32;
			w = {w, string'(c)};
		end
		case (w)
			"ALTER", "CREATE", "DELETE", "DROP", "INSERT", "SELECT", "UPDATE": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic void flush_ident();
		if (kw_possible && kw_live && pend_is_keyword())
			close_stmt();
		for (int i = 0; i < pend_n; i++)
			emit_text(pend[i]);
		pend_n      = 0;
		kw_possible = 1'b1;
		kw_live     = 1'b1;
		tm          = TM_GAP;
	endfunction

	function automatic void open_token(input logic [7:0] c);
		tm = TM_GAP;
		if (c == ";") begin
			close_stmt();
		end else if (c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0C) begin
			emit_text(c);
			kw_live = 1'b1;
			tm = TM_SPACE;
		end else if (is_punct(c)) begin
			emit_text(c);
			kw_live = 1'b1;
		end else if (c == ChBacktick || c == ChApos) begin
			emit_text(c);
			kw_live = 1'b1;
			quote_bt = (c == ChBacktick);
			tm = TM_QUOTE;
		end else if (is_digit(c)) begin
			emit_text(c);
			kw_live = 1'b1;
			tm = TM_DIGITS;
		end else if (c == "[") begin
			emit_text(c);
			kw_live = 1'b1;
			tm = TM_BRACKET;
		end else if (is_ident(c)) begin
			pend[0] = c;
			pend_n = 1;
			kw_possible = 1'b1;
			tm = TM_IDENT;
		end else begin
			emit_text(c);
			close_stmt();
		end
	endfunction

	function automatic void take_text(input logic [7:0] c);
		case (tm)
			TM_SPACE: begin
				if (is_ws_cont(c))
					emit_text(c);
				else
					open_token(c);
			end
			TM_DIGITS: begin
				if (is_digit(c))
					emit_text(c);
				else
					open_token(c);
			end
			TM_QUOTE: begin
				emit_text(c);
				if (c == (quote_bt ? ChBacktick : ChApos))
					tm = TM_GAP;
			end
			TM_BRACKET: begin
				emit_text(c);
				if (c == "]")
					tm = TM_GAP;
			end
			TM_IDENT: begin
				if (!is_ident(c)) begin
					flush_ident();
					open_token(c);
				end else if (!kw_possible) begin
					emit_text(c);
				end else if (pend_n < sqs_pkg::HoldMax) begin
					pend[pend_n] = c;
					pend_n++;
				end else begin
					for (int i = 0; i < sqs_pkg::HoldMax; i++)
						emit_text(pend[i]);
					emit_text(c);
					pend_n = 0;
					kw_possible = 1'b0;
				end
			end
			default: open_token(c);
		endcase
	endfunction

	function automatic void split_step(input sqs_pkg::sqs_in_t x, output int n);
		sqs_pkg::sqs_out_t tail;
		step_res.delete();
		if (x.cmd == sqs_pkg::CMD_FINISH) begin
			if (tm == TM_IDENT)
				flush_ident();
			close_stmt();
			tm = TM_GAP;
			pend_n = 0;
			kw_possible = 1'b1;
		end else begin
			take_text(x.data_byte);
		end
		if (step_res.size() > 0) begin
			tail = step_res.pop_back();
			tail.last = 1'b1;
			step_res.push_back(tail);
		end
		n = step_res.size();
		foreach (step_res[k])
			split_out_q.push_back(step_res[k]);
	endfunction

	// ---------------- random SQL text ----------------

	function automatic void push_text(input logic [7:0] c);
		rand_q.push_back({sqs_pkg::CMD_BYTE, c});
	endfunction

	function automatic logic [7:0] ident_byte(input bit first);
		case ($urandom_range(0, 11))
			0, 1, 2, 3: return 8'($urandom_range(65, 90));
			4, 5, 6, 7: return 8'($urandom_range(97, 122));
			8: return "_";
			9: return 8'h05;
			10: return 8'($urandom_range(128, 255));
			default: return first ? "_" : ($urandom_range(0, 1) ? 8'h2D : 8'($urandom_range(48, 57)));
		endcase
	endfunction

	function automatic logic [7:0] body_byte(input logic [7:0] stop);
		logic [7:0] c;
		c = 8'($urandom);
		return (c == stop) ? "x" : c;
	endfunction

	function automatic void build_random_stream();
		int         r;
		int         len;
		string      kw;
		logic [7:0] c;
		logic [7:0] q;
		while (rand_q.size() < RandItems) begin
			r = $urandom_range(0, 99);
			if (r < 25) begin
				kw = kw_list[$urandom_range(0, 6)];
				len = kw.len();
				if ($urandom_range(0, 9) == 0)
					len--;
				for (int i = 0; i < len; i++) begin
					c = kw[i];
					if ($urandom_range(0, 1))
						c = c + 8'd32;
					push_text(c);
				end
				if ($urandom_range(0, 9) == 0)
					push_text(ident_byte(1'b0));
			end else if (r < 40) begin
				len = $urandom_range(1, 10);
				push_text(ident_byte(1'b1));
				for (int i = 1; i < len; i++)
					push_text(ident_byte(1'b0));
			end else if (r < 55) begin
				push_text(ws_set[$urandom_range(0, 3)]);
				repeat ($urandom_range(0, 2))
					push_text(ws_set[$urandom_range(0, 4)]);
			end else if (r < 63) begin
				push_text(punct_set[$urandom_range(0, 10)]);
			end else if (r < 68) begin
				q = $urandom_range(0, 1) ? ChBacktick : ChApos;
				push_text(q);
				repeat ($urandom_range(0, 4))
					push_text(body_byte(q));
				push_text(q);
			end else if (r < 72) begin
				push_text("[");
				repeat ($urandom_range(0, 4))
					push_text(body_byte("]"));
				push_text("]");
			end else if (r < 77) begin
				repeat ($urandom_range(1, 4))
					push_text(8'($urandom_range(48, 57)));
			end else if (r < 85) begin
				push_text(";");
			end else if (r < 89) begin
				rand_q.push_back({sqs_pkg::CMD_FINISH, 8'($urandom)});
			end else if (r < 93) begin
				push_text(unk_set[$urandom_range(0, 7)]);
			end else begin
				rand_q.push_back({($urandom_range(0, 7) == 0) ? sqs_pkg::CMD_FINISH :
					sqs_pkg::CMD_BYTE, 8'($urandom)});
			end
		end
	endfunction

	// ---------------- sender ----------------

	task automatic send_item(input sqs_pkg::sqs_in_t x, output int n);
		item <= x;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		split_step(x, n);
	endtask

	task automatic idle_sender(input int cycles);
		item_valid <= 1'b0;
		repeat (cycles)
			@(posedge clk);
	endtask

	initial begin
		int               n;
		int               rush;
		int               want_idx;
		sqs_pkg::sqs_in_t x;
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		item       <= '0;
		rush = 0;
		build_random_stream();
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DirRows; r++) begin
			x = {dir_tab[r].cmd, dir_tab[r].b};
			send_item(x, n);
			if (dir_tab[r].chk) begin
				want_idx = split_out_q.size() - n;
				if (n != dir_tab[r].n)
					report_mismatch("directed result count", n, dir_tab[r].n);
				else if (n > 0 && split_out_q[want_idx] != dir_tab[r].first)
					report_mismatch("directed first result", split_out_q[want_idx],
						dir_tab[r].first);
			end
			if ($urandom_range(0, 3) == 0)
				idle_sender($urandom_range(1, 14));
		end

		for (int i = 0; i < rand_q.size(); i++) begin
			if (i == HoldAt) begin
				hold_req = 1'b1;
				rush = 40;
			end
			if (i >= rand_q.size() - TailItems)
				tail_quiet = 1'b1;
			send_item(rand_q[i], n);
			if (rush > 0)
				rush--;
			if (i == DrainAt) begin
				item_valid <= 1'b0;
				do
					@(posedge clk);
				while (split_out_q.size() != 0);
			end else if (!tail_quiet && rush == 0 && $urandom_range(0, 3) == 0) begin
				idle_sender($urandom_range(1, 14));
			end
		end

		item_valid <= 1'b0;
		while (split_out_q.size() != 0)
			@(posedge clk);
		repeat (30)
			@(posedge clk);
		if (mismatches == 0)
			$display("sql_statement_splitter_top regression: pass");
		else
			$display("sql_statement_splitter_top regression: fail");
		$finish;
	end

	// ---------------- receiver ----------------

	initial begin
		int hold_cnt;
		result_stall <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				for (hold_cnt = 0; hold_cnt < HoldCycles; hold_cnt++)
					@(posedge clk);
				result_stall <= 1'b0;
				@(posedge clk);
			end else if (!tail_quiet && $urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 14))
					@(posedge clk);
				result_stall <= 1'b0;
				@(posedge clk);
			end else begin
				repeat ($urandom_range(1, 20))
					@(posedge clk);
			end
		end
	end

	// ---------------- result check ----------------

	always @(posedge clk) begin
		sqs_pkg::sqs_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (split_out_q.size() == 0) begin
				report_mismatch("unexpected result transaction", result, 0);
			end else begin
				want = split_out_q.pop_front();
				if (result.kind != want.kind)
					report_mismatch("kind", result.kind, want.kind);
				if (result.out_byte != want.out_byte)
					report_mismatch("out_byte", result.out_byte, want.out_byte);
				if (result.last != want.last)
					report_mismatch("last", result.last, want.last);
			end
		end
	end

endmodule
